// ===== rtl/csc_pkg.sv =====
// ============================================================================
// csc_pkg
// Shared types, constants and arithmetic helpers of the coordinate converter.
// ============================================================================
package csc_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    localparam int VW = 54;
    localparam int ZW = 38;
    localparam int CW = 34;
    localparam int MW = 36;
    localparam int PW = 38;

    localparam logic [2:0] OP_SPH2CART = 3'd0;
    localparam logic [2:0] OP_CYL2CART = 3'd1;
    localparam logic [2:0] OP_CART2SPH = 3'd2;
    localparam logic [2:0] OP_CART2CYL = 3'd3;
    localparam logic [2:0] OP_DIST     = 3'd4;

    localparam logic [29:0]          KINV_Q30    = 30'd652032874;
    localparam logic signed [ZW-1:0] PI_U32      = 38'sd13493037705;
    localparam logic signed [ZW-1:0] HALF_PI_U32 = 38'sd6746518852;
    localparam logic signed [ZW-1:0] TWO_PI_U32  = 38'sd26986075409;
    localparam logic signed [ZW-1:0] PI_Q28      = 38'sd843314857;
    localparam logic signed [ZW-1:0] TWO_PI_Q28  = 38'sd1686629713;

    typedef struct packed {
        logic [2:0]           op;
        logic signed [31:0]   a0;
        logic signed [31:0]   a2;
        logic signed [32:0]   dz;
        logic signed [VW-1:0] rho;
        logic signed [ZW-1:0] phi;
        logic signed [CW-1:0] cp;
        logic signed [CW-1:0] sp;
        logic signed [CW-1:0] ct;
        logic signed [CW-1:0] st;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_tab(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 38'sd3373259426;
            1:  v = 38'sd1991351318;
            2:  v = 38'sd1052175346;
            3:  v = 38'sd534100635;
            4:  v = 38'sd268086748;
            5:  v = 38'sd134174063;
            6:  v = 38'sd67103403;
            7:  v = 38'sd33553749;
            8:  v = 38'sd16777131;
            9:  v = 38'sd8388597;
            10: v = 38'sd4194303;
            11: v = 38'sd2097152;
            12: v = 38'sd1048576;
            13: v = 38'sd524288;
            14: v = 38'sd262144;
            15: v = 38'sd131072;
            16: v = 38'sd65536;
            17: v = 38'sd32768;
            18: v = 38'sd16384;
            19: v = 38'sd8192;
            20: v = 38'sd4096;
            21: v = 38'sd2048;
            22: v = 38'sd1024;
            23: v = 38'sd512;
            24: v = 38'sd256;
            25: v = 38'sd128;
            26: v = 38'sd64;
            27: v = 38'sd32;
            28: v = 38'sd16;
            29: v = 38'sd8;
            30: v = 38'sd4;
            31: v = 38'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
        logic signed [31:0] r;
        if (v > 54'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -54'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [PW-1:0] mul_q30(input logic signed [MW-1:0] a,
                                                     input logic signed [MW-1:0] b);
        logic signed [2*MW-1:0] p;
        p = a * b + (72'sd1 <<< 29);
        return p[PW+29:30];
    endfunction

endpackage

// ===== rtl/csc_rotate.sv =====
// ============================================================================
// csc_rotate
// Pipelined rotation CORDIC giving cosine and sine of a Q4.28 angle in Q.30.
// ============================================================================
module csc_rotate (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [31:0]              i_ang,
    output logic signed [csc_pkg::CW-1:0]   o_cos,
    output logic signed [csc_pkg::CW-1:0]   o_sin
);

    localparam int N = csc_pkg::STEPS;
    localparam int CW = csc_pkg::CW;
    localparam int ZW = csc_pkg::ZW;

    logic signed [CW-1:0] r_x [0:N];
    logic signed [CW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic                 r_flip [0:N];
    logic signed [CW-1:0] r_c1, r_s1;

    logic signed [ZW-1:0] n_z;
    logic                 n_flip;
    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] z_wr;

    always_comb begin
        z_in = {{2{i_ang[31]}}, i_ang, 4'b0000};
        if (z_in >= csc_pkg::PI_U32) begin
            z_wr = z_in - csc_pkg::TWO_PI_U32;
        end else if (z_in < -csc_pkg::PI_U32) begin
            z_wr = z_in + csc_pkg::TWO_PI_U32;
        end else begin
            z_wr = z_in;
        end
        n_flip = 1'b0;
        n_z    = z_wr;
        if (z_wr > csc_pkg::HALF_PI_U32) begin
            n_z    = z_wr - csc_pkg::PI_U32;
            n_flip = 1'b1;
        end else if (z_wr < -csc_pkg::HALF_PI_U32) begin
            n_z    = z_wr + csc_pkg::PI_U32;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CW'(signed'({1'b0, csc_pkg::KINV_Q30}));
            r_y[0]    <= '0;
            r_z[0]    <= n_z;
            r_flip[0] <= n_flip;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [CW-1:0] n_x, n_y;
        logic signed [ZW-1:0] n_zs;
        always_comb begin
            if (r_z[i] >= 0) begin
                n_x  = r_x[i] - (r_y[i] >>> i);
                n_y  = r_y[i] + (r_x[i] >>> i);
                n_zs = r_z[i] - csc_pkg::atan_tab(i);
            end else begin
                n_x  = r_x[i] + (r_y[i] >>> i);
                n_y  = r_y[i] - (r_x[i] >>> i);
                n_zs = r_z[i] + csc_pkg::atan_tab(i);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_zs;
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1  <= r_flip[N] ? -r_x[N] : r_x[N];
            r_s1  <= r_flip[N] ? -r_y[N] : r_y[N];
            o_cos <= r_c1;
            o_sin <= r_s1;
        end
    end

endmodule

// ===== rtl/csc_vector.sv =====
// ============================================================================
// csc_vector
// Pipelined vectoring CORDIC giving magnitude and atan2, with gain correction.
// ============================================================================
module csc_vector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [csc_pkg::VW-1:0]   i_x,
    input  logic signed [csc_pkg::VW-1:0]   i_y,
    input  csc_pkg::t_side                  i_side,
    output logic                            o_valid,
    output logic signed [csc_pkg::VW-1:0]   o_mag,
    output logic signed [csc_pkg::ZW-1:0]   o_ang,
    output csc_pkg::t_side                  o_side
);

    localparam int N = csc_pkg::STEPS;
    localparam int VW = csc_pkg::VW;
    localparam int ZW = csc_pkg::ZW;

    logic signed [VW-1:0] r_x [0:N];
    logic signed [VW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic                 r_spec [0:N];
    logic                 r_valid [0:N];
    csc_pkg::t_side       r_side [0:N];

    logic [51:0]          r_ph;
    logic [61:0]          r_pl;
    logic signed [VW-1:0] r_gx;
    logic signed [ZW-1:0] r_gz;
    logic                 r_gspec;
    logic                 r_gvalid;
    csc_pkg::t_side       r_gside;

    logic signed [VW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic                 n_spec;

    always_comb begin
        n_x    = i_x;
        n_y    = i_y;
        n_z    = '0;
        n_spec = 1'b0;
        if (i_y == 0) begin
            n_spec = 1'b1;
            n_x    = (i_x < 0) ? -i_x : i_x;
            n_z    = (i_x < 0) ? csc_pkg::PI_U32 : '0;
        end else if (i_x == 0) begin
            n_spec = 1'b1;
            n_x    = (i_y < 0) ? -i_y : i_y;
            n_z    = (i_y < 0) ? -csc_pkg::HALF_PI_U32 : csc_pkg::HALF_PI_U32;
        end else if (i_x < 0) begin
            n_z = (i_y > 0) ? csc_pkg::PI_U32 : -csc_pkg::PI_U32;
            n_x = -i_x;
            n_y = -i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_spec[0] <= n_spec;
            r_side[0] <= i_side;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [VW-1:0] s_x, s_y;
        logic signed [ZW-1:0] s_z;
        always_comb begin
            s_x = r_x[i];
            s_y = r_y[i];
            s_z = r_z[i];
            if (!r_spec[i]) begin
                if (r_y[i] >= 0) begin
                    s_x = r_x[i] + (r_y[i] >>> i);
                    s_y = r_y[i] - (r_x[i] >>> i);
                    s_z = r_z[i] + csc_pkg::atan_tab(i);
                end else begin
                    s_x = r_x[i] - (r_y[i] >>> i);
                    s_y = r_y[i] + (r_x[i] >>> i);
                    s_z = r_z[i] - csc_pkg::atan_tab(i);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= s_x;
                r_y[i+1]    <= s_y;
                r_z[i+1]    <= s_z;
                r_spec[i+1] <= r_spec[i];
                r_side[i+1] <= r_side[i];
            end
        end
    end

    // The gain product is split at bit 32 into two partial products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvalid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r_gvalid <= r_valid[N];
            o_valid  <= r_gvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph    <= 52'(r_x[N][VW-1:32]) * 52'(csc_pkg::KINV_Q30);
            r_pl    <= 62'(r_x[N][31:0]) * 62'(csc_pkg::KINV_Q30) + 62'(32'h20000000);
            r_gx    <= r_x[N];
            r_gz    <= r_z[N];
            r_gspec <= r_spec[N];
            r_gside <= r_side[N];
            o_mag   <= r_gspec ? r_gx : signed'(VW'({r_ph, 2'b00}) + VW'(r_pl[61:30]));
            o_ang   <= r_gz;
            o_side  <= r_gside;
        end
    end

endmodule

// ===== rtl/csc_output.sv =====
// ============================================================================
// csc_output
// Final products, rounding, angle wrapping and result selection per mode.
// ============================================================================
module csc_output (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [csc_pkg::VW-1:0]   i_mag,
    input  logic signed [csc_pkg::ZW-1:0]   i_ang,
    input  csc_pkg::t_side                  i_side,
    output logic                            o_valid,
    output logic signed [31:0]              o_r0,
    output logic signed [31:0]              o_r1,
    output logic signed [31:0]              o_r2,
    output logic                            o_err
);

    localparam int VW = csc_pkg::VW;
    localparam int ZW = csc_pkg::ZW;
    localparam int MW = csc_pkg::MW;
    localparam int PW = csc_pkg::PW;

    logic                 r_valid;
    logic [2:0]           r_op;
    logic signed [31:0]   r_a0, r_a2;
    logic signed [PW-1:0] r_p1, r_p2, r_p3;
    logic signed [31:0]   r_umag, r_urho, r_phi, r_th;

    logic signed [PW-1:0] n_p1, n_p2, n_p3;
    logic signed [ZW-1:0] pa, pq, tq;
    logic signed [31:0]   n_phi, n_th;
    logic signed [MW-1:0] a0w;

    always_comb begin
        a0w  = MW'(i_side.a0);
        n_p1 = csc_pkg::mul_q30(MW'(i_side.cp), MW'(i_side.st));
        n_p2 = csc_pkg::mul_q30(MW'(i_side.sp), MW'(i_side.st));
        n_p3 = csc_pkg::mul_q30(a0w, MW'(i_side.ct));
        if (i_side.op == csc_pkg::OP_CYL2CART) begin
            n_p1 = csc_pkg::mul_q30(a0w, MW'(i_side.cp));
            n_p2 = csc_pkg::mul_q30(a0w, MW'(i_side.sp));
        end

        pa = i_side.phi;
        if (pa < 0) begin
            pa = pa + csc_pkg::TWO_PI_U32;
        end else if (pa >= csc_pkg::TWO_PI_U32) begin
            pa = pa - csc_pkg::TWO_PI_U32;
        end
        pq = (pa + 38'sd8) >>> 4;
        if (pq >= csc_pkg::TWO_PI_Q28) begin
            pq = pq - csc_pkg::TWO_PI_Q28;
        end
        n_phi = pq[31:0];

        tq = (i_ang + 38'sd8) >>> 4;
        if (i_ang <= 0) begin
            tq = '0;
        end else if (tq > csc_pkg::PI_Q28) begin
            tq = csc_pkg::PI_Q28;
        end
        n_th = tq[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            o_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op   <= i_side.op;
            r_a0   <= i_side.a0;
            r_a2   <= i_side.a2;
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_p3   <= n_p3;
            r_umag <= csc_pkg::sat32((i_mag + VW'(32'h8000)) >>> 16);
            r_urho <= csc_pkg::sat32((i_side.rho + VW'(32'h8000)) >>> 16);
            r_phi  <= n_phi;
            r_th   <= n_th;
        end
    end

    logic signed [31:0] n_r0, n_r1, n_r2;
    logic               n_err;

    always_comb begin
        n_r0  = '0;
        n_r1  = '0;
        n_r2  = '0;
        n_err = 1'b0;
        case (r_op)
            csc_pkg::OP_SPH2CART: begin
                n_r0 = csc_pkg::sat32(VW'(csc_pkg::mul_q30(MW'(r_a0), r_p1[MW-1:0])));
                n_r1 = csc_pkg::sat32(VW'(csc_pkg::mul_q30(MW'(r_a0), r_p2[MW-1:0])));
                n_r2 = csc_pkg::sat32(VW'(r_p3));
            end
            csc_pkg::OP_CYL2CART: begin
                n_r0 = csc_pkg::sat32(VW'(r_p1));
                n_r1 = csc_pkg::sat32(VW'(r_p2));
                n_r2 = r_a2;
            end
            csc_pkg::OP_CART2SPH: begin
                n_r0 = r_umag;
                n_r1 = r_phi;
                n_r2 = r_th;
            end
            csc_pkg::OP_CART2CYL: begin
                n_r0 = r_urho;
                n_r1 = r_phi;
                n_r2 = r_a2;
            end
            csc_pkg::OP_DIST: begin
                n_r0 = r_umag;
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_r0  <= n_r0;
            o_r1  <= n_r1;
            o_r2  <= n_r2;
            o_err <= n_err;
        end
    end

endmodule

// ===== rtl/coordinate_system_converter_top.sv =====
// ============================================================================
// coordinate_system_converter_top
// Converts 3D points between Cartesian, spherical and cylindrical form, or
// gives the distance between two points, one word per cycle.
// The datapath is two chained vectoring pipelines and the final multipliers.
// Throughput is one word per cycle; the whole pipeline holds when the output
// word waits, and a new word is taken in the cycle the output is taken.
// Reset clears only the valid bits; the data registers are not reset.
// ============================================================================
module coordinate_system_converter_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [191:0] i_s_axis_tdata,  // a_0, a_1, a_2, b_0, b_1, b_2
    input  logic [2:0]   i_s_axis_tuser,  // operation
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,  // out_0, out_1, out_2
    output logic [0:0]   o_m_axis_tuser   // error
);

    localparam int VW = csc_pkg::VW;
    localparam int ZW = csc_pkg::ZW;
    localparam int CW = csc_pkg::CW;

    logic en;
    logic out_valid;

    assign en              = !out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = out_valid;

    logic signed [31:0] a0, a1, a2, b0, b1, b2;
    logic signed [32:0] dx, dy, dz;
    logic               is_dist;
    csc_pkg::t_side     side1;

    assign a0 = i_s_axis_tdata[31:0];
    assign a1 = i_s_axis_tdata[63:32];
    assign a2 = i_s_axis_tdata[95:64];
    assign b0 = i_s_axis_tdata[127:96];
    assign b1 = i_s_axis_tdata[159:128];
    assign b2 = i_s_axis_tdata[191:160];

    always_comb begin
        is_dist = (i_s_axis_tuser == csc_pkg::OP_DIST);
        dx = is_dist ? 33'(a0) - 33'(b0) : 33'(a0);
        dy = is_dist ? 33'(a1) - 33'(b1) : 33'(a1);
        dz = is_dist ? 33'(a2) - 33'(b2) : 33'(a2);
        side1     = '0;
        side1.op  = i_s_axis_tuser;
        side1.a0  = a0;
        side1.a2  = a2;
        side1.dz  = dz;
    end

    logic signed [CW-1:0] cp, sp, ct, st;

    csc_rotate u_rot_phi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (a1),
        .o_cos (cp),
        .o_sin (sp)
    );

    csc_rotate u_rot_theta (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (a2),
        .o_cos (ct),
        .o_sin (st)
    );

    logic                 v1_valid;
    logic signed [VW-1:0] v1_mag;
    logic signed [ZW-1:0] v1_ang;
    csc_pkg::t_side       v1_side;

    csc_vector u_vec1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_x     ({{5{dx[32]}}, dx, 16'h0000}),
        .i_y     ({{5{dy[32]}}, dy, 16'h0000}),
        .i_side  (side1),
        .o_valid (v1_valid),
        .o_mag   (v1_mag),
        .o_ang   (v1_ang),
        .o_side  (v1_side)
    );

    csc_pkg::t_side side2;

    always_comb begin
        side2     = v1_side;
        side2.rho = v1_mag;
        side2.phi = v1_ang;
        side2.cp  = cp;
        side2.sp  = sp;
        side2.ct  = ct;
        side2.st  = st;
    end

    logic                 v2_valid;
    logic signed [VW-1:0] v2_mag;
    logic signed [ZW-1:0] v2_ang;
    csc_pkg::t_side       v2_side;

    csc_vector u_vec2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1_valid),
        .i_x     ({{5{v1_side.dz[32]}}, v1_side.dz, 16'h0000}),
        .i_y     (v1_mag),
        .i_side  (side2),
        .o_valid (v2_valid),
        .o_mag   (v2_mag),
        .o_ang   (v2_ang),
        .o_side  (v2_side)
    );

    logic signed [31:0] r0, r1, r2;
    logic               err;

    csc_output u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2_valid),
        .i_mag   (v2_mag),
        .i_ang   (v2_ang),
        .i_side  (v2_side),
        .o_valid (out_valid),
        .o_r0    (r0),
        .o_r1    (r1),
        .o_r2    (r2),
        .o_err   (err)
    );

    assign o_m_axis_tdata = {r2, r1, r0};
    assign o_m_axis_tuser = err;

endmodule
